>>> src/ptu_pkg.sv
// Shared constants and types for the planar tile unpacker.
// Used by the pixel lanes, the group merge stage and the top level.
package ptu_pkg;

  localparam int SubtilesAcross      = 2;
  localparam int SubtilesDown        = 3;
  localparam int SubtileLines        = 16;
  localparam int SubtilePixelsAcross = 32;
  localparam int BlockPixels         = 8;
  localparam int BlocksPerRow        = SubtilePixelsAcross / BlockPixels;
  localparam int BlockIdxWidth       = $clog2(BlocksPerRow);
  localparam int TilePixelsAcross    = SubtilesAcross * SubtilePixelsAcross;
  localparam int PlaneCount          = 4;
  localparam int IndexWidth          = 12;
  localparam int PixelWidth          = 8;
  localparam int GroupWidth          = BlockPixels * PixelWidth;
  localparam int InDataWidth         = 168;
  localparam int OutDataWidth        = 80;
  localparam int OutUserWidth        = 2;

  localparam logic [PixelWidth-1:0] TransparentPixel = 8'hFF;
  localparam logic [BlockIdxWidth-1:0] LastBlock = BlockIdxWidth'(BlocksPerRow - 1);

  // Per-result status that rides along with each pixel group
  typedef struct packed {
    logic tile_done;
    logic all_transparent;
    logic last_of_run;
  } ptu_flags_t;

endpackage

>>> src/ptu_pixel_lane.sv
// One pixel lane: turns a mask bit and four plane bits into a chunky pixel.
// Depends on ptu_pkg.
module ptu_pixel_lane (
  input  logic                                    mask_bit_i,
  input  logic [ptu_pkg::PlaneCount-1:0]          plane_bits_i,
  output logic [ptu_pkg::PixelWidth-1:0]          pixel_o,
  output logic                                    opaque_o
);
  import ptu_pkg::*;

  always_comb begin
    if (mask_bit_i) begin
      pixel_o = TransparentPixel;
    end else begin
      pixel_o = {{(PixelWidth - PlaneCount){1'b0}}, plane_bits_i};
    end
  end

  assign opaque_o = ~mask_bit_i;

endmodule

>>> src/ptu_group_merge.sv
// Merge stage: gathers the lane pixels into one group and holds the result
// register that drives the output stream. Depends on ptu_pkg.
module ptu_group_merge (
  input  logic                                         clk_i,
  input  logic                                         rst_ni,
  input  logic                                         valid_i,
  output logic                                         ready_o,
  input  logic [ptu_pkg::BlockPixels-1:0][ptu_pkg::PixelWidth-1:0] pixels_i,
  input  logic [ptu_pkg::BlockPixels-1:0]              opaque_i,
  input  logic [ptu_pkg::IndexWidth-1:0]               index_i,
  input  ptu_pkg::ptu_flags_t                          flags_i,
  output logic                                         block_opaque_o,
  output logic                                         m_axis_tvalid,
  input  logic                                         m_axis_tready,
  // tdata: pixel_index [11:0], pixel_group [75:12], zero fill [79:76]
  output logic [ptu_pkg::OutDataWidth-1:0]             m_axis_tdata,
  // tuser: tile_done [0], all_transparent [1]
  output logic [ptu_pkg::OutUserWidth-1:0]             m_axis_tuser,
  output logic                                         m_axis_tlast
);
  import ptu_pkg::*;

  logic                    valid_q;
  logic [IndexWidth-1:0]   index_q;
  logic [GroupWidth-1:0]   group_q;
  ptu_flags_t              flags_q;
  logic [GroupWidth-1:0]   group_d;

  assign ready_o        = ~valid_q | m_axis_tready;
  assign block_opaque_o = |opaque_i;

  // Leftmost pixel lands in the low byte
  always_comb begin
    for (int i = 0; i < BlockPixels; i++) begin
      group_d[i*PixelWidth +: PixelWidth] = pixels_i[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      index_q <= index_i;
      group_q <= group_d;
      flags_q <= flags_i;
    end
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = {{(OutDataWidth - GroupWidth - IndexWidth){1'b0}}, group_q, index_q};
  assign m_axis_tuser  = {flags_q.all_transparent, flags_q.tile_done};
  assign m_axis_tlast  = flags_q.last_of_run;

endmodule

>>> src/planar_tile_unpacker_core.sv
// Top level of the planar tile unpacker: row holding stage, eight pixel lanes
// and the group merge stage. Depends on ptu_pkg, ptu_pixel_lane, ptu_group_merge.
//
// Each input transfer carries one 32-pixel subtile row (mask plus four bit
// planes) and produces four output transfers of eight 8-bit pixels, left block
// first; a masked pixel reads 255. Eight lanes convert one block per cycle
// while the output register accepts, and a new row is taken in the cycle its fourth block
// moves into the output register. The output register decouples the two sides:
// one finished group may wait on m_axis_tready while the next is prepared.
// tlast marks the fourth group of every row; on a row with s_axis_tlast set,
// tuser reports tile done and whether the whole tile was transparent, and the
// transparency tracking restarts for the next tile. A row is registered in the holding
// stage before its groups are registered in the output register.
module planar_tile_unpacker_core (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  // tdata: subtile_col [0], subtile_row [2:1], line_number [6:3],
  //        mask_bits [38:7], plane_zero [70:39], plane_one [102:71],
  //        plane_two [134:103], plane_three [166:135], zero fill [167]
  input  logic [ptu_pkg::InDataWidth-1:0]        s_axis_tdata,
  input  logic                                   s_axis_tlast,
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  // tdata: pixel_index [11:0], pixel_group [75:12], zero fill [79:76]
  output logic [ptu_pkg::OutDataWidth-1:0]       m_axis_tdata,
  // tuser: tile_done [0], all_transparent [1]
  output logic [ptu_pkg::OutUserWidth-1:0]       m_axis_tuser,
  output logic                                   m_axis_tlast
);
  import ptu_pkg::*;

  // Unpacked input fields
  logic                  in_col;
  logic [1:0]            in_row;
  logic [3:0]            in_line;
  logic [31:0]           in_mask;
  logic [PlaneCount-1:0][31:0] in_planes;

  assign in_col       = s_axis_tdata[0];
  assign in_row       = s_axis_tdata[2:1];
  assign in_line      = s_axis_tdata[6:3];
  assign in_mask      = s_axis_tdata[38:7];
  assign in_planes[0] = s_axis_tdata[70:39];
  assign in_planes[1] = s_axis_tdata[102:71];
  assign in_planes[2] = s_axis_tdata[134:103];
  assign in_planes[3] = s_axis_tdata[166:135];

  // Row holding stage
  logic                        hold_valid_q;
  logic [BlockIdxWidth-1:0]    blk_q;
  logic [IndexWidth-1:0]       base_q;
  logic [IndexWidth-1:0]       base_d;
  logic [31:0]                 mask_q;
  logic [PlaneCount-1:0][31:0] planes_q;
  logic                        done_q;
  logic                        clear_q;
  logic                        clear_d;

  logic                        in_xfer;
  logic                        merge_ready;
  logic                        advance;
  logic                        last_blk;

  assign advance       = hold_valid_q & merge_ready;
  assign last_blk      = (blk_q == LastBlock);
  assign s_axis_tready = ~hold_valid_q | (advance & last_blk);
  assign in_xfer       = s_axis_tvalid & s_axis_tready;

  // Tile index of the row's first pixel, saturated position, wraps at 12 bits
  logic [IndexWidth-1:0] col_sat, row_sat, line_sat, row_flip, line_flip;

  always_comb begin
    col_sat  = (IndexWidth'(in_col) >= IndexWidth'(SubtilesAcross)) ?
               IndexWidth'(SubtilesAcross - 1) : IndexWidth'(in_col);
    row_sat  = (IndexWidth'(in_row) >= IndexWidth'(SubtilesDown)) ?
               IndexWidth'(SubtilesDown - 1) : IndexWidth'(in_row);
    line_sat = (IndexWidth'(in_line) >= IndexWidth'(SubtileLines)) ?
               IndexWidth'(SubtileLines - 1) : IndexWidth'(in_line);
    row_flip  = IndexWidth'(SubtilesDown - 1) - row_sat;
    line_flip = IndexWidth'(SubtileLines - 1) - line_sat;
    base_d = (row_flip * IndexWidth'(SubtileLines) + line_flip)
             * IndexWidth'(TilePixelsAcross)
             + col_sat * IndexWidth'(SubtilePixelsAcross);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_valid_q <= 1'b0;
      blk_q        <= '0;
      clear_q      <= 1'b1;
    end else begin
      if (in_xfer) begin
        hold_valid_q <= 1'b1;
        blk_q        <= '0;
      end else if (advance) begin
        blk_q <= blk_q + 1'b1;
        if (last_blk) begin
          hold_valid_q <= 1'b0;
        end
      end
      if (advance) begin
        clear_q <= clear_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      base_q   <= base_d;
      mask_q   <= in_mask;
      planes_q <= in_planes;
      done_q   <= s_axis_tlast;
    end
  end

  // Current block bytes
  logic [4:0]                          byte_sel;
  logic [BlockPixels-1:0]              blk_mask;
  logic [PlaneCount-1:0][BlockPixels-1:0] blk_planes;

  assign byte_sel = {blk_q, 3'b000};

  always_comb begin
    blk_mask = mask_q[byte_sel +: BlockPixels];
    for (int p = 0; p < PlaneCount; p++) begin
      blk_planes[p] = planes_q[p][byte_sel +: BlockPixels];
    end
  end

  // Pixel lanes: lane i takes bit 7-i of the block byte
  logic [BlockPixels-1:0][PixelWidth-1:0] lane_pixels;
  logic [BlockPixels-1:0]                 lane_opaque;

  for (genvar i = 0; i < BlockPixels; i++) begin : g_lane
    logic [PlaneCount-1:0] lane_planes;
    for (genvar p = 0; p < PlaneCount; p++) begin : g_bit
      assign lane_planes[p] = blk_planes[p][BlockPixels-1-i];
    end
    ptu_pixel_lane u_lane (
      .mask_bit_i   (blk_mask[BlockPixels-1-i]),
      .plane_bits_i (lane_planes),
      .pixel_o      (lane_pixels[i]),
      .opaque_o     (lane_opaque[i])
    );
  end

  // Result flags and running transparency
  logic        block_opaque;
  logic        clear_run;
  logic        tile_end;
  ptu_flags_t  flags;
  logic [IndexWidth-1:0] blk_index;

  assign clear_run = clear_q & ~block_opaque;
  assign tile_end  = last_blk & done_q;
  assign clear_d   = tile_end ? 1'b1 : clear_run;
  assign blk_index = base_q + IndexWidth'(blk_q) * IndexWidth'(BlockPixels);

  always_comb begin
    flags.tile_done       = tile_end;
    flags.all_transparent = tile_end & clear_run;
    flags.last_of_run     = last_blk;
  end

  ptu_group_merge u_merge (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .valid_i        (hold_valid_q),
    .ready_o        (merge_ready),
    .pixels_i       (lane_pixels),
    .opaque_i       (lane_opaque),
    .index_i        (blk_index),
    .flags_i        (flags),
    .block_opaque_o (block_opaque),
    .m_axis_tvalid  (m_axis_tvalid),
    .m_axis_tready  (m_axis_tready),
    .m_axis_tdata   (m_axis_tdata),
    .m_axis_tuser   (m_axis_tuser),
    .m_axis_tlast   (m_axis_tlast)
  );

  // A tile end is only reported on the last group of a row
  a_done_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tlast)
    else $error("tile_done without last_of_run");

  // Transparency is only reported together with tile end
  a_transp_with_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tuser[0])
    else $error("all_transparent without tile_done");

  // A fresh row occupies the holding stage for at least the next cycle
  a_row_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("new row taken before current row drained");

  // Rows leave the holding stage only after their last block advanced
  a_row_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hold_valid_q && !(advance && last_blk) |=> hold_valid_q)
    else $error("row dropped before all blocks sent");

endmodule

>>> bench/tb_planar_tile_unpacker_core.sv
// Self-checking bench for planar_tile_unpacker_core: directed rows, then random tiles.
// Predicts every pixel group, index and tile flag in SystemVerilog; depends on ptu_pkg.
// Both stream sides idle and stall at random while results are checked in order.
module tb_planar_tile_unpacker_core;
  import ptu_pkg::*;

  typedef struct packed {
    logic            eot;
    logic [3:0][31:0] planes;
    logic [31:0]     mask;
    logic [3:0]      line;
    logic [1:0]      row;
    logic            col;
  } tile_row_t;

  typedef struct packed {
    logic [IndexWidth-1:0] index;
    logic [GroupWidth-1:0] group;
    logic                  done;
    logic                  clear;
    logic                  last;
  } pix_group_t;

  // typed rows carry the first block's index and pixels and the tile flags of the fourth
  typedef struct packed {
    tile_row_t             item;
    logic                  typed;
    logic [IndexWidth-1:0] t_index;
    logic [GroupWidth-1:0] t_group;
    logic                  t_done;
    logic                  t_clear;
  } stim_row_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    s_axis_tvalid = 1'b0;
  logic                    s_axis_tready;
  logic [InDataWidth-1:0]  s_axis_tdata = '0;
  logic                    s_axis_tlast = 1'b0;
  logic                    m_axis_tvalid;
  logic                    m_axis_tready = 1'b0;
  logic [OutDataWidth-1:0] m_axis_tdata;
  logic [OutUserWidth-1:0] m_axis_tuser;
  logic                    m_axis_tlast;

  pix_group_t pending_groups[$];
  stim_row_t  directed_rows[$];
  logic       tile_clear = 1'b1;
  int         mismatch_cnt = 0;
  int         rows_sent = 0;
  int         hold_cnt = 0;
  bit         calm = 1'b0;

  planar_tile_unpacker_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #4 clk_i = ~clk_i;

  function automatic int pick_gap();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    else return $urandom_range(8, 40);
  endfunction

  function automatic stim_row_t mk_row(logic col, logic [1:0] row, logic [3:0] line,
                                       logic [31:0] mask, logic [31:0] p0, logic [31:0] p1,
                                       logic [31:0] p2, logic [31:0] p3, logic eot,
                                       logic typed, logic [IndexWidth-1:0] t_index,
                                       logic [GroupWidth-1:0] t_group, logic t_done,
                                       logic t_clear);
    stim_row_t s;
    s.item.col = col;
    s.item.row = row;
    s.item.line = line;
    s.item.mask = mask;
    s.item.planes = {p3, p2, p1, p0};
    s.item.eot = eot;
    s.typed = typed;
    s.t_index = t_index;
    s.t_group = t_group;
    s.t_done = t_done;
    s.t_clear = t_clear;
    return s;
  endfunction

  // Convert one subtile row into its four pixel groups and update the tile flag
  task automatic convert_row(input tile_row_t r, output pix_group_t res[4]);
    int          c, rw, ln, base, b;
    logic [7:0]  px;
    c  = (r.col >= SubtilesAcross) ? SubtilesAcross - 1 : r.col;
    rw = (r.row >= SubtilesDown) ? SubtilesDown - 1 : r.row;
    ln = (r.line >= SubtileLines) ? SubtileLines - 1 : r.line;
    base = ((SubtilesDown - 1 - rw) * SubtileLines + (SubtileLines - 1 - ln))
           * TilePixelsAcross + c * SubtilePixelsAcross;
    if (r.mask != 32'hFFFF_FFFF) tile_clear = 1'b0;
    for (int j = 0; j < BlocksPerRow; j++) begin
      res[j].group = '0;
      for (int i = 0; i < BlockPixels; i++) begin
        b = BlockPixels * j + (BlockPixels - 1 - i);
        if (r.mask[b]) px = TransparentPixel;
        else px = {4'b0, r.planes[3][b], r.planes[2][b], r.planes[1][b], r.planes[0][b]};
        res[j].group[PixelWidth*i +: PixelWidth] = px;
      end
      res[j].index = IndexWidth'(base + BlockPixels * j);
      res[j].last  = (j == BlocksPerRow - 1);
      res[j].done  = res[j].last && r.eot;
      res[j].clear = res[j].last && r.eot && tile_clear;
    end
    if (r.eot) tile_clear = 1'b1;
  endtask

  task automatic send_row(input stim_row_t s);
    pix_group_t res[4];
    @(negedge clk_i);
    s_axis_tdata  <= {1'b0, s.item.planes, s.item.mask, s.item.line, s.item.row, s.item.col};
    s_axis_tlast  <= s.item.eot;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    convert_row(s.item, res);
    if (s.typed) begin
      res[0].index = s.t_index;
      res[0].group = s.t_group;
      res[3].done  = s.t_done;
      res[3].clear = s.t_clear;
    end
    for (int j = 0; j < 4; j++) pending_groups.push_back(res[j]);
    rows_sent++;
    calm = ((rows_sent / 40) % 4) == 3;
  endtask

  task automatic idle_sender(input int n);
    repeat (n) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
    end
  endtask

  task automatic maybe_pause();
    if (!calm && $urandom_range(0, 99) < 30) idle_sender(pick_gap());
  endtask

  task automatic drain_results();
    idle_sender(1);
    while (pending_groups.size() != 0) @(posedge clk_i);
  endtask

  task automatic flag_mismatch(input string what, input pix_group_t want, input pix_group_t got);
    mismatch_cnt++;
    if (mismatch_cnt <= 10) begin
      $write("mismatch (%s): exp idx=%0d grp=%h done=%b clr=%b last=%b, ",
             what, want.index, want.group, want.done, want.clear, want.last);
      $display("got idx=%0d grp=%h done=%b clr=%b last=%b",
               got.index, got.group, got.done, got.clear, got.last);
    end
  endtask

  // Stall the result side at random, with calm stretches
  always @(negedge clk_i) begin
    if (hold_cnt > 0) begin
      m_axis_tready <= 1'b0;
      hold_cnt = hold_cnt - 1;
    end else if (!calm && $urandom_range(0, 99) < 25) begin
      m_axis_tready <= 1'b0;
      hold_cnt = pick_gap() - 1;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    pix_group_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.index = m_axis_tdata[IndexWidth-1:0];
      got.group = m_axis_tdata[IndexWidth +: GroupWidth];
      got.done  = m_axis_tuser[0];
      got.clear = m_axis_tuser[1];
      got.last  = m_axis_tlast;
      if (pending_groups.size() == 0) begin
        flag_mismatch("no result expected", '0, got);
      end else begin
        want = pending_groups.pop_front();
        if (got.index !== want.index) flag_mismatch("pixel_index", want, got);
        if (got.group !== want.group) flag_mismatch("pixel_group", want, got);
        if (got.done !== want.done) flag_mismatch("tile_done", want, got);
        if (got.clear !== want.clear) flag_mismatch("all_transparent", want, got);
        if (got.last !== want.last) flag_mismatch("last_of_run", want, got);
      end
    end
  end

  initial begin
    #4000000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    stim_row_t   s;
    int          tile_len, n_items;
    bit          see_through;
    logic [31:0] m;

    //                      col   row   line   mask          p0            p1
    //                      p2            p3            eot   typed idx   group
    directed_rows.push_back(mk_row(1'b0, 2'd0, 4'd0, 32'hFFFF_FFFF, 32'h0, 32'h0,
      32'h0, 32'h0, 1'b1, 1'b1, 12'd3008, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b1));
    directed_rows.push_back(mk_row(1'b1, 2'd2, 4'd15, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
      32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1, 12'd32, 64'h0F0F_0F0F_0F0F_0F0F, 1'b1, 1'b0));
    // row code beyond the last subtile saturates
    directed_rows.push_back(mk_row(1'b0, 2'd3, 4'd0, 32'h0, 32'h0, 32'h0,
      32'h0, 32'h0, 1'b0, 1'b1, 12'd960, 64'h0, 1'b0, 1'b0));
    directed_rows.push_back(mk_row(1'b0, 2'd1, 4'd7, 32'h0, 32'h0000_0080, 32'h0,
      32'h0, 32'h0, 1'b0, 1'b1, 12'd1536, 64'h1, 1'b0, 1'b0));
    directed_rows.push_back(mk_row(1'b1, 2'd1, 4'd8, 32'h0, 32'h0, 32'h0,
      32'h0, 32'h0000_0001, 1'b0, 1'b1, 12'd1504, 64'h0800_0000_0000_0000, 1'b0, 1'b0));
    directed_rows.push_back(mk_row(1'b0, 2'd0, 4'd15, 32'h0, 32'h0, 32'h0000_0040,
      32'h0, 32'h0, 1'b1, 1'b1, 12'd2048, 64'h200, 1'b1, 1'b0));
    directed_rows.push_back(mk_row(1'b1, 2'd1, 4'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
      32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b0, '0, '0, 1'b0, 1'b0));
    directed_rows.push_back(mk_row(1'b1, 2'd2, 4'd0, 32'hFFFF_FFFF, 32'h0, 32'h0,
      32'h0, 32'h0, 1'b1, 1'b1, 12'd992, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b1));
    // one opaque pixel is enough to clear the tile flag
    directed_rows.push_back(mk_row(1'b0, 2'd0, 4'd0, 32'hFFFF_FFFE, 32'h0, 32'h0,
      32'h0, 32'h0, 1'b1, 1'b1, 12'd3008, 64'h00FF_FFFF_FFFF_FFFF, 1'b1, 1'b0));
    directed_rows.push_back(mk_row(1'b1, 2'd1, 4'd10, 32'h7FFF_FFFF, 32'h8000_0000,
      32'h0, 32'h8000_0000, 32'h0, 1'b0, 1'b0, '0, '0, 1'b0, 1'b0));
    directed_rows.push_back(mk_row(1'b0, 2'd2, 4'd15, 32'hFFFF_FFFF, 32'h0, 32'h0,
      32'h0, 32'h0, 1'b1, 1'b1, 12'd0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b0));
    directed_rows.push_back(mk_row(1'b0, 2'd0, 4'd5, 32'h5555_5555, 32'hAAAA_AAAA,
      32'hCCCC_CCCC, 32'hF0F0_F0F0, 32'hFF00_FF00, 1'b0, 1'b0, '0, '0, 1'b0, 1'b0));
    directed_rows.push_back(mk_row(1'b1, 2'd3, 4'd9, 32'hAAAA_AAAA, 32'h1234_5678,
      32'h9ABC_DEF0, 32'h0F1E_2D3C, 32'hA5A5_A5A5, 1'b0, 1'b0, '0, '0, 1'b0, 1'b0));
    directed_rows.push_back(mk_row(1'b0, 2'd1, 4'd4, 32'h00FF_00FF, 32'hFFFF_0000,
      32'h0000_FFFF, 32'hFF00_FF00, 32'h00FF_00FF, 1'b1, 1'b0, '0, '0, 1'b0, 1'b0));
    directed_rows.push_back(mk_row(1'b1, 2'd2, 4'd15, 32'h0, 32'h0, 32'h0,
      32'h0, 32'h0, 1'b0, 1'b1, 12'd32, 64'h0, 1'b0, 1'b0));
    directed_rows.push_back(mk_row(1'b0, 2'd1, 4'd12, 32'h0, 32'hFFFF_FFFF, 32'h0,
      32'h0, 32'h0, 1'b1, 1'b0, '0, '0, 1'b0, 1'b0));
    directed_rows.push_back(mk_row(1'b1, 2'd0, 4'd1, 32'h0, 32'h0, 32'h0,
      32'hFFFF_FFFF, 32'h0, 1'b0, 1'b0, '0, '0, 1'b0, 1'b0));
    directed_rows.push_back(mk_row(1'b0, 2'd3, 4'd14, 32'hFF00_FF00, 32'h8181_8181,
      32'h8181_8181, 32'h8181_8181, 32'h8181_8181, 1'b0, 1'b0, '0, '0, 1'b0, 1'b0));
    directed_rows.push_back(mk_row(1'b1, 2'd3, 4'd15, 32'hFFFF_FFFF, 32'h0, 32'h0,
      32'h0, 32'h0, 1'b1, 1'b0, '0, '0, 1'b0, 1'b0));
    directed_rows.push_back(mk_row(1'b1, 2'd0, 4'd15, 32'hFFFF_FFFF, 32'h0, 32'h0,
      32'h0, 32'h0, 1'b1, 1'b1, 12'd2080, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b1));

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[k]) begin
      send_row(directed_rows[k]);
      maybe_pause();
    end
    // hold the sender until the result side has caught up
    drain_results();

    n_items = 0;
    while (n_items < 330) begin
      tile_len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      see_through = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < tile_len; k++) begin
        if (see_through) begin
          m = 32'hFFFF_FFFF;
          if ($urandom_range(0, 19) == 0) m[5'($urandom_range(0, 31))] = 1'b0;
        end else begin
          case ($urandom_range(0, 19))
            0, 1, 2, 3: m = 32'h0;
            4, 5, 6:    m = 32'hFFFF_FFFF;
            7, 8, 9:    m = $urandom() & $urandom();
            default:    m = $urandom();
          endcase
        end
        s = mk_row(1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
                   4'($urandom_range(0, 15)), m,
                   $urandom(), $urandom(), $urandom(), $urandom(),
                   k == tile_len - 1, 1'b0, '0, '0, 1'b0, 1'b0);
        if ($urandom_range(0, 9) == 0) s.item.planes = {4{($urandom_range(0, 1) != 0) ?
                                                         32'hFFFF_FFFF : 32'h0}};
        send_row(s);
        n_items++;
        maybe_pause();
      end
      if (n_items >= 165 && n_items - tile_len < 165) drain_results();
    end

    drain_results();
    repeat (16) @(posedge clk_i);
    if (pending_groups.size() != 0) flag_mismatch("result never came", pending_groups[0], '0);
    if (mismatch_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> files.f
src/ptu_pkg.sv
src/ptu_pixel_lane.sv
src/ptu_group_merge.sv
src/planar_tile_unpacker_core.sv
bench/tb_planar_tile_unpacker_core.sv
